@@ hdl/sitoa_pkg.sv @@
// shared constants and control/status types for the signed integer to decimal text block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sitoa_pkg;

    localparam int VALUE_WIDTH   = 32;
    // input tdata is the value padded up to whole bytes
    localparam int S_TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = 8;

    // double dabble: magnitude bits consumed per conversion cycle
    localparam int BITS_PER_STEP = 4;
    localparam int SHIFT_STEPS   = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_WIDTH     = SHIFT_STEPS * BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(SHIFT_STEPS);

    // decimal digits of 2^(VALUE_WIDTH-1), the largest magnitude
    localparam int MAX_DIGITS    = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int PTR_W         = $clog2(MAX_DIGITS);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic load;
        logic step;
        logic find;
        logic emit_sign;
        logic emit_digit;
    } sitoa_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic neg;
        logic ptr_zero;
        logic out_free;
    } sitoa_status_t;

endpackage

@@ hdl/signed_int_to_decimal_ascii.sv @@
// top level: signed integer to decimal ascii text, one character per output transfer
// depends on sitoa_pkg, sitoa_ctrl and sitoa_dp
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata = value (VALUE_WIDTH bits, two's complement)
// m_        out  m_tvalid/m_tready    m_tdata = char_code, m_tlast = is_last
//
// sequence: one transfer accepted, then double dabble steps through the bcd shift
//   register (four magnitude bits per cycle), a search for the leading digit, then
//   one character per cycle while the output is not stalled by m_tready
// reset: aresetn synchronous, active low; clears the controller and output valid
// stalls: a held m_tready pauses emission only; the last character may wait in
//   the output register while the next value is already accepted

module signed_int_to_decimal_ascii (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sitoa_pkg::S_TDATA_WIDTH-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sitoa_pkg::M_TDATA_WIDTH-1:0] m_tdata,   // [7:0] char_code
    output logic                                m_tlast    // is_last
);
    import sitoa_pkg::*;

    sitoa_cmd_t    cmd;
    sitoa_status_t status;

    // state machine: load, convert, find leading digit, sign, digits
    sitoa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // magnitude, bcd digits and the output register
    sitoa_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hdl/sitoa_dp.sv @@
// datapath: magnitude, bcd shift register, digit pointer and output register
// depends on sitoa_pkg
`timescale 1ns / 1ps

module sitoa_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [sitoa_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    input  sitoa_pkg::sitoa_cmd_t               cmd,
    output sitoa_pkg::sitoa_status_t            status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sitoa_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    output logic                                m_tlast
);
    import sitoa_pkg::*;

    logic [VALUE_WIDTH-1:0]         raw;
    logic [VALUE_WIDTH-1:0]         mag;
    logic                           neg_reg;
    logic [PAD_WIDTH-1:0]           bin_reg, bin_next;
    logic [MAX_DIGITS-1:0][3:0]     bcd_reg, bcd_next;
    logic [STEP_CNT_W-1:0]          step_cnt_reg;
    logic [PTR_W-1:0]               ptr_reg, lead;
    logic                           m_tvalid_reg;
    logic [M_TDATA_WIDTH-1:0]       m_tdata_reg;
    logic                           m_tlast_reg;

    assign raw = s_tdata[VALUE_WIDTH-1:0];
    assign mag = raw[VALUE_WIDTH-1] ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

    // BITS_PER_STEP add-3-and-shift steps per cycle
    always_comb begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                if (bcd_next[d] >= 4'd5) begin
                    bcd_next[d] = bcd_next[d] + 4'd3;
                end
            end
            {bcd_next, bin_next} = {bcd_next, bin_next} << 1;
        end
    end

    // most significant non-zero digit, or the units digit for zero
    always_comb begin
        lead = '0;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd_reg[d] != 4'd0) begin
                lead = PTR_W'(d);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg      <= raw[VALUE_WIDTH-1];
            bin_reg      <= PAD_WIDTH'(mag);
            bcd_reg      <= '0;
            step_cnt_reg <= '0;
        end else if (cmd.step) begin
            bin_reg      <= bin_next;
            bcd_reg      <= bcd_next;
            step_cnt_reg <= step_cnt_reg + 1'b1;
        end
        if (cmd.find) begin
            ptr_reg <= lead;
        end else if (cmd.emit_digit && ptr_reg != '0) begin
            ptr_reg <= ptr_reg - 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            m_tdata_reg <= CHAR_MINUS;
            m_tlast_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            m_tdata_reg <= CHAR_ZERO + {4'b0000, bcd_reg[ptr_reg]};
            m_tlast_reg <= (ptr_reg == '0);
        end
    end

    assign status.conv_last = (step_cnt_reg == STEP_CNT_W'(SHIFT_STEPS - 1));
    assign status.neg       = neg_reg;
    assign status.ptr_zero  = (ptr_reg == '0);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ hdl/sitoa_ctrl.sv @@
// controller: sequences load, conversion, leading digit search and character emission
// depends on sitoa_pkg
`timescale 1ns / 1ps

module sitoa_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  sitoa_pkg::sitoa_status_t status,
    output sitoa_pkg::sitoa_cmd_t    cmd
);
    import sitoa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (status.conv_last) begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                cmd.find   = 1'b1;
                state_next = status.neg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.ptr_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

@@ hdl/sitoa_checker.sv @@
// port-level checker for signed_int_to_decimal_ascii, attached by bind
// depends on sitoa_pkg
`timescale 1ns / 1ps

module sitoa_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [sitoa_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    input logic                                m_tlast
);
    import sitoa_pkg::*;

    // a stalled output transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // only minus or a decimal digit is ever emitted
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == CHAR_MINUS) || (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE))
        else $error("character outside the decimal set");

    // the sign is never the final character of a run
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == CHAR_MINUS |-> !m_tlast)
        else $error("minus sign flagged as last");

    // one value at a time: conversion follows every accepted transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after an accepted transfer");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
